// ===== sv/pbbh_pkg.sv =====
`default_nettype none

package pbbh_pkg;

	// Field widths fixed by the item and register formats.
	localparam int POS_W   = 32;
	localparam int INV_W   = 32;
	localparam int GRID_W  = 13;
	localparam int IDX_W   = 12;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 32;
	localparam int CFG_A_W = 3;

	// Dividend width of the shared dividers: ceil(grid / bucket) needs one bit more
	// than a grid size.
	localparam int DIV_W   = GRID_W + 1;
	localparam int PROD_W  = 2 * DIV_W;
	localparam int BKT_W   = PROD_W + 1;

	localparam int MAX_BUCKETS_DEF = 4096;

	localparam logic [POS_W-1:0]  ORIGIN_RST = '0;
	localparam logic [INV_W-1:0]  INV_RST    = 32'd65536;
	localparam logic [GRID_W-1:0] GRID_RST   = 13'd64;
	localparam logic [GRID_W-1:0] BCELL_RST  = 13'd1;
	localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

	typedef enum logic [1:0] {
		MODE_BIN      = 2'd0,
		MODE_READ     = 2'd1,
		MODE_READ_CLR = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_ORIGIN_X  = 3'd0,
		CFG_ORIGIN_Y  = 3'd1,
		CFG_INV_X     = 3'd2,
		CFG_INV_Y     = 3'd3,
		CFG_GRID_X    = 3'd4,
		CFG_GRID_Y    = 3'd5,
		CFG_BUCKET_X  = 3'd6,
		CFG_BUCKET_Y  = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP_DIV,
		ST_PREP_MUL,
		ST_SUB,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_BKT,
		ST_RDA,
		ST_MEMRD,
		ST_BAD
	} state_t;

endpackage

`default_nettype wire

// ===== sv/pbbh_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient holds after done
// until the next start.
module pbbh_div
	import pbbh_pkg::*;
#(
	parameter int W = DIV_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    partial;
	logic [W:0]    diff;
	logic          ge;

	always_comb begin
		partial = {rem_q, quo_q[W-1]};
		diff    = partial - {1'b0, dvs_q};
		ge      = ~diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : partial[W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== sv/particle_bucket_binning_histogram_top.sv =====
// A read or read-and-clear beat passes the memory read state into the output register;
// a binned particle passes SUB, MUL, CHK, DIV, BKT, RDA and MEMRD, mostly in the two bucket dividers.
// Items are taken one at a time: a new beat is accepted only after the last result is loaded.
// Reset clears the registers and then sweeps the count memory, one entry per cycle,
// over every entry; the bucket geometry is then worked out by the dividers, and again
// after every configuration write. The input is stalled during both.
`default_nettype none

module particle_bucket_binning_histogram_top
	import pbbh_pkg::*;
#(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                cfg_we,
	input  wire logic [CFG_A_W-1:0]  cfg_idx,
	input  wire logic [CFG_W-1:0]    cfg_wdata,

	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          mode,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic                dead,
	input  wire logic [IDX_W-1:0]    query_bucket,

	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [IDX_W-1:0]         bucket_index,
	output logic                     valid_res,
	output logic [CNT_W-1:0]         count
);

	// Address width of the count memory; a single-entry memory still gets one bit.
	localparam int ABW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

	// Configuration registers.
	logic [POS_W-1:0]  origin_x_q, origin_y_q;
	logic [INV_W-1:0]  inv_x_q, inv_y_q;
	logic [GRID_W-1:0] grid_x_q, grid_y_q;
	logic [GRID_W-1:0] bcell_x_q, bcell_y_q;

	// Bucket geometry derived from the configuration. dirty_q asks for it to be rebuilt.
	logic              dirty_q;
	logic [DIV_W-1:0]  nbx_q, nby_q;
	logic [PROD_W-1:0] total_q;

	state_t            state_q, state_d;
	logic [ABW-1:0]    clr_q;

	// Item registers.
	mode_t             mode_q;
	logic [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [POS_W-1:0]  mag_x_q, mag_y_q;
	logic              neg_x_q, neg_y_q;
	logic [63:0]       prod_x_q, prod_y_q;
	logic [BKT_W-1:0]  b_q;

	// Output register.
	logic              out_valid_q;
	logic [IDX_W-1:0]  bucket_index_q;
	logic              valid_res_q;
	logic [CNT_W-1:0]  count_q;

	// Count memory.
	logic [CNT_W-1:0]  mem [0:MAX_BUCKETS-1];
	logic [CNT_W-1:0]  rd_data_q;

	logic              accept;
	logic              out_free;
	logic              start_prep;
	logic              start_item;
	logic              rd_en;
	logic [ABW-1:0]    rd_addr;
	logic              mem_we;
	logic [ABW-1:0]    mem_wa;
	logic [CNT_W-1:0]  mem_wd;
	logic              load_out;
	logic              res_ok;
	logic [CNT_W-1:0]  res_count;
	logic              query_ok;
	logic              bin_ok;
	logic              bkt_ok;
	logic              chk_bad;
	logic [31:0]       cell_x, cell_y;
	logic [CNT_W-1:0]  cnt_inc;

	logic [POS_W:0]    dx, dy;
	logic [POS_W-1:0]  mag_x_d, mag_y_d;

	logic              div_start;
	logic [DIV_W-1:0]  dvd_x, dvd_y, dvs_x, dvs_y;
	logic              done_x, done_y;
	logic [DIV_W-1:0]  quo_x, quo_y;
	logic [PROD_W-1:0] bkt_prod;

	// ---------------------------------------------------------------------------
	// Configuration writes. Each write marks the bucket geometry stale; it is
	// recomputed once the writes stop, before the next beat is taken.
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORIGIN_RST;
			origin_y_q <= ORIGIN_RST;
			inv_x_q    <= INV_RST;
			inv_y_q    <= INV_RST;
			grid_x_q   <= GRID_RST;
			grid_y_q   <= GRID_RST;
			bcell_x_q  <= BCELL_RST;
			bcell_y_q  <= BCELL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_ORIGIN_X: origin_x_q <= cfg_wdata;
				CFG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				CFG_INV_X:    inv_x_q    <= cfg_wdata;
				CFG_INV_Y:    inv_y_q    <= cfg_wdata;
				CFG_GRID_X:   grid_x_q   <= cfg_wdata[GRID_W-1:0];
				CFG_GRID_Y:   grid_y_q   <= cfg_wdata[GRID_W-1:0];
				CFG_BUCKET_X: bcell_x_q  <= cfg_wdata[GRID_W-1:0];
				CFG_BUCKET_Y: bcell_y_q  <= cfg_wdata[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b1;
		end else if (cfg_we) begin
			dirty_q <= 1'b1;
		end else if (start_prep) begin
			dirty_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------------
	// Handshake. A beat is taken only in IDLE with the geometry current and no configuration
	// write. The output register lets a new beat in while the previous result still waits.
	// ---------------------------------------------------------------------------
	assign in_stall = !((state_q == ST_IDLE) && !dirty_q && !cfg_we);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Offsets from the origin are exact in 33 bits; keep the magnitude and the sign.
	always_comb begin
		dx      = {pos_x_q[POS_W-1], pos_x_q} - {origin_x_q[POS_W-1], origin_x_q};
		dy      = {pos_y_q[POS_W-1], pos_y_q} - {origin_y_q[POS_W-1], origin_y_q};
		mag_x_d = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
		mag_y_d = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
	end

	// The floor of the product over 2^32 is the cell. A negative offset is outside
	// unless the product is zero, which lands in cell zero.
	always_comb begin
		cell_x  = prod_x_q[63:32];
		cell_y  = prod_y_q[63:32];
		chk_bad = (neg_x_q && (prod_x_q != '0)) || (neg_y_q && (prod_y_q != '0)) ||
			(cell_x >= 32'(grid_x_q)) || (cell_y >= 32'(grid_y_q));
	end

	assign query_ok = 32'(query_bucket) < 32'(MAX_BUCKETS);
	assign bin_ok   = !dead && (bcell_x_q != '0) && (bcell_y_q != '0);
	assign bkt_ok   = (b_q < BKT_W'(total_q)) && (32'(b_q) < 32'(MAX_BUCKETS));
	assign cnt_inc  = (rd_data_q == CNT_MAX) ? rd_data_q : rd_data_q + CNT_W'(1);

	// ---------------------------------------------------------------------------
	// Sequencer.
	// ---------------------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		start_prep = 1'b0;
		start_item = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = b_q[ABW-1:0];
		mem_we     = 1'b0;
		mem_wa     = b_q[ABW-1:0];
		mem_wd     = '0;
		load_out   = 1'b0;
		res_ok     = 1'b0;
		res_count  = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == ABW'(MAX_BUCKETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (dirty_q && !cfg_we) begin
					start_prep = 1'b1;
					state_d    = ST_PREP_DIV;
				end else if (accept) begin
					case (mode_t'(mode))
						MODE_BIN: begin
							state_d = bin_ok ? ST_SUB : ST_BAD;
						end
						MODE_READ, MODE_READ_CLR: begin
							if (query_ok) begin
								rd_en   = 1'b1;
								rd_addr = ABW'(query_bucket);
								state_d = ST_MEMRD;
							end else begin
								state_d = ST_BAD;
							end
						end
						default: begin
							state_d = ST_BAD;
						end
					endcase
				end
			end
			ST_PREP_DIV: begin
				if (done_x) begin
					state_d = ST_PREP_MUL;
				end
			end
			ST_PREP_MUL: begin
				state_d = ST_IDLE;
			end
			ST_SUB: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (chk_bad) begin
					state_d = ST_BAD;
				end else begin
					start_item = 1'b1;
					state_d    = ST_DIV;
				end
			end
			ST_DIV: begin
				if (done_x) begin
					state_d = ST_BKT;
				end
			end
			ST_BKT: begin
				state_d = ST_RDA;
			end
			ST_RDA: begin
				if (bkt_ok) begin
					rd_en   = 1'b1;
					state_d = ST_MEMRD;
				end else begin
					state_d = ST_BAD;
				end
			end
			ST_MEMRD: begin
				// Read-modify-write of one entry for bin and read-and-clear. Items run one at a time and
				// the next read comes only after this state is left, so nothing needs forwarding.
				if (out_free) begin
					load_out = 1'b1;
					res_ok   = 1'b1;
					state_d  = ST_IDLE;
					case (mode_q)
						MODE_BIN: begin
							mem_we    = 1'b1;
							mem_wd    = cnt_inc;
							res_count = cnt_inc;
						end
						MODE_READ_CLR: begin
							mem_we    = 1'b1;
							res_count = rd_data_q;
						end
						default: begin
							res_count = rd_data_q;
						end
					endcase
				end
			end
			ST_BAD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ABW'(1);
			end
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode_t'(mode);
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			b_q     <= BKT_W'(query_bucket);
		end
		if (state_q == ST_SUB) begin
			mag_x_q <= mag_x_d;
			mag_y_q <= mag_y_d;
			neg_x_q <= dx[POS_W];
			neg_y_q <= dy[POS_W];
		end
		if (state_q == ST_MUL) begin
			prod_x_q <= 64'(mag_x_q) * 64'(inv_x_q);
			prod_y_q <= 64'(mag_y_q) * 64'(inv_y_q);
		end
		if (state_q == ST_BKT) begin
			b_q <= BKT_W'(bkt_prod) + BKT_W'(quo_y);
		end
		if ((state_q == ST_PREP_DIV) && done_x) begin
			nbx_q <= quo_x;
			nby_q <= quo_y;
		end
		if (state_q == ST_PREP_MUL) begin
			total_q <= PROD_W'(nbx_q) * PROD_W'(nby_q);
		end
	end

	assign bkt_prod = PROD_W'(quo_x) * PROD_W'(nby_q);

	// ---------------------------------------------------------------------------
	// Dividers: ceil(grid / bucket) while the geometry is rebuilt, cell / bucket for
	// each particle.
	// ---------------------------------------------------------------------------
	assign div_start = start_prep || start_item;

	always_comb begin
		if (state_q == ST_IDLE) begin
			dvd_x = DIV_W'(grid_x_q) + DIV_W'(bcell_x_q) - DIV_W'(1);
			dvd_y = DIV_W'(grid_y_q) + DIV_W'(bcell_y_q) - DIV_W'(1);
		end else begin
			dvd_x = DIV_W'(cell_x[GRID_W-1:0]);
			dvd_y = DIV_W'(cell_y[GRID_W-1:0]);
		end
		dvs_x = DIV_W'(bcell_x_q);
		dvs_y = DIV_W'(bcell_y_q);
	end

	pbbh_div #(
		.W(DIV_W)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_x),
		.divisor  (dvs_x),
		.done     (done_x),
		.quotient (quo_x)
	);

	pbbh_div #(
		.W(DIV_W)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_y),
		.divisor  (dvs_y),
		.done     (done_y),
		.quotient (quo_y)
	);

	// ---------------------------------------------------------------------------
	// Count memory: one write port, one read port with registered data.
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// ---------------------------------------------------------------------------
	// Output register. An invalid result carries zero index and zero count.
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			valid_res_q    <= res_ok;
			bucket_index_q <= res_ok ? b_q[IDX_W-1:0] : '0;
			count_q        <= res_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign valid_res    = valid_res_q;
	assign bucket_index = bucket_index_q;
	assign count        = count_q;

	// ---------------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------------
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q)
		else $error("result presented during the memory clearing pass");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !valid_res_q) |-> ((bucket_index_q == '0) && (count_q == '0)))
		else $error("invalid result with nonzero index or count");

	a_bin_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MEMRD) && out_free && (mode_q == MODE_BIN)) |=> (count_q != '0))
		else $error("binned particle reported a zero count");

	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !rd_en)
		else $error("count memory read and written in the same cycle");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_x == done_y)
		else $error("dividers out of step");

endmodule

`default_nettype wire
